FILE: rtl/kic_pkg.sv
`default_nettype none

package kic_pkg;

   localparam int unsigned MAX_CHARS      = 15;
   localparam int unsigned CNT_W          = $clog2(MAX_CHARS + 1);
   localparam int unsigned OUT_TEXT_BYTES = 15;
   localparam int unsigned LENGTH_W       = 4;
   localparam int unsigned WORD_INDEX_W   = 5;
   localparam int unsigned KW_MAX_LEN     = 9;
   localparam int unsigned N_OP_WORDS     = 6;
   localparam int unsigned N_RES_WORDS    = 29;

   typedef logic [7:0]                  char_type;
   typedef logic [MAX_CHARS-1:0][7:0]   text_type;
   typedef logic [CNT_W-1:0]            count_type;
   typedef logic [WORD_INDEX_W-1:0]     word_index_type;
   typedef logic [8*KW_MAX_LEN-1:0]     kw_text_type;

   typedef enum logic [1:0] {
      KIND_IDENT    = 2'd0,
      KIND_OPERATOR = 2'd1,
      KIND_RESERVED = 2'd2
   } kind_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

   // string literals hold character 0 in the highest used byte
   localparam kw_text_type OP_WORDS [N_OP_WORDS] = '{
      "and", "or", "not", "div", "mod", "in"
   };
   localparam int unsigned OP_LENS [N_OP_WORDS] = '{3, 2, 3, 3, 3, 2};

   localparam kw_text_type RES_WORDS [N_RES_WORDS] = '{
      "array", "begin", "case", "const", "do", "downto", "else", "end",
      "file", "for", "function", "goto", "if", "label", "nil", "of",
      "packed", "procedure", "program", "record", "repeat", "set", "then",
      "to", "type", "while", "var", "until", "with"
   };
   localparam int unsigned RES_LENS [N_RES_WORDS] = '{
      5, 5, 4, 5, 2, 6, 4, 3,
      4, 3, 8, 4, 2, 5, 3, 2,
      6, 9, 7, 6, 6, 3, 4,
      2, 4, 5, 3, 5, 4
   };

   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHAR_UPPER_Z = 8'h5a;
   localparam char_type CASE_OFFSET  = 8'h20;

   function automatic logic word_equal(input text_type word, input count_type count,
                                       input kw_text_type kw, input int unsigned len);
      logic eq;
      eq = (count == CNT_W'(len));
      for (int unsigned j = 0; j < KW_MAX_LEN; j++) begin
         if (j < len) begin
            if (word[j] != kw[8*(len-1-j) +: 8]) begin
               eq = 1'b0;
            end
         end
      end
      return eq;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/kic_in_stage.sv
`default_nettype none

module kic_in_stage import kic_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic [7:0]    req_character,
   input  wire logic          req_last,
   input  wire logic          advance,
   output logic               req_stall,
   output stage_ctl_type      ctl,
   output char_type           char_out
);

   stage_ctl_type ctl_ff, ctl_in;
   char_type      char_ff, char_in;
   logic          load;

   assign req_stall = ctl_ff.valid && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      ctl_in = ctl_ff;
      char_in = char_ff;
      if (load) begin
         ctl_in.valid = 1'b1;
         ctl_in.last  = req_last;
         // fold capitals to lower case
         if (req_character >= CHAR_UPPER_A && req_character <= CHAR_UPPER_Z) begin
            char_in = req_character + CASE_OFFSET;
         end else begin
            char_in = req_character;
         end
      end else if (advance) begin
         ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      char_ff <= char_in;
   end

   assign ctl      = ctl_ff;
   assign char_out = char_ff;

endmodule

`default_nettype wire

FILE: rtl/kic_buffer.sv
`default_nettype none

module kic_buffer import kic_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire stage_ctl_type ctl,
   input  wire char_type      char_in,
   output text_type           word,
   output count_type          count
);

   text_type  text_ff, text_in;
   count_type count_ff, count_in;
   text_type  merged;
   count_type merged_count;

   // word as it stands with the current character added
   always_comb begin
      merged = text_ff;
      merged_count = count_ff;
      if (count_ff < CNT_W'(MAX_CHARS)) begin
         merged_count = count_ff + 1'b1;
         for (int unsigned i = 0; i < MAX_CHARS; i++) begin
            if (count_ff == CNT_W'(i)) begin
               merged[i] = char_in;
            end
         end
      end
   end

   always_comb begin
      text_in = text_ff;
      count_in = count_ff;
      if (advance) begin
         if (ctl.last) begin
            text_in = '0;
            count_in = '0;
         end else begin
            text_in = merged;
            count_in = merged_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_ff <= '0;
         count_ff <= '0;
      end else begin
         text_ff <= text_in;
         count_ff <= count_in;
      end
   end

   assign word  = merged;
   assign count = merged_count;

endmodule

`default_nettype wire

FILE: rtl/kic_match.sv
`default_nettype none

module kic_match import kic_pkg::*; (
   input  wire text_type       word,
   input  wire count_type      count,
   output kind_type            kind,
   output word_index_type      word_index
);

   logic           op_hit, res_hit;
   word_index_type op_index, res_index;

   // table words are distinct, so at most one entry of each table hits
   always_comb begin
      op_hit = 1'b0;
      op_index = '0;
      for (int unsigned i = 0; i < N_OP_WORDS; i++) begin
         if (word_equal(word, count, OP_WORDS[i], OP_LENS[i])) begin
            op_hit = 1'b1;
            op_index = WORD_INDEX_W'(i);
         end
      end
      res_hit = 1'b0;
      res_index = '0;
      for (int unsigned i = 0; i < N_RES_WORDS; i++) begin
         if (word_equal(word, count, RES_WORDS[i], RES_LENS[i])) begin
            res_hit = 1'b1;
            res_index = WORD_INDEX_W'(i);
         end
      end
   end

   always_comb begin
      priority if (op_hit) begin
         kind = KIND_OPERATOR;
         word_index = op_index;
      end else if (res_hit) begin
         kind = KIND_RESERVED;
         word_index = res_index;
      end else begin
         kind = KIND_IDENT;
         word_index = '0;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/keyword_identifier_classifier.sv
// the last character is held in the input stage, then rsp_valid is registered
// one character per cycle unless a held result blocks, one word per identifier
// timing is set by the single compare stage between the input and result registers
// reset clears the valid flags, the text buffer and the kept count
`default_nettype none

module keyword_identifier_classifier import kic_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_character,
   input  wire logic          req_last,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [4:0]         rsp_word_index,
   output logic [63:0]        rsp_text_first,
   output logic [55:0]        rsp_text_rest,
   output logic [3:0]         rsp_length
);

   stage_ctl_type  ctl;
   char_type       stage_char;
   text_type       word;
   count_type      count;
   kind_type       kind;
   word_index_type word_index;
   logic           advance;
   logic           load;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                kind_ff;
   word_index_type          index_ff;
   logic [63:0]             first_ff, first_in;
   logic [55:0]             rest_ff, rest_in;
   logic [LENGTH_W-1:0]     length_ff, length_in;

   assign advance = ctl.valid && (!ctl.last || !rsp_valid_ff || !rsp_stall);
   assign load    = advance && ctl.last;

   kic_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_last      (req_last),
      .advance       (advance),
      .req_stall     (req_stall),
      .ctl           (ctl),
      .char_out      (stage_char)
   );

   kic_buffer u_buffer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctl     (ctl),
      .char_in (stage_char),
      .word    (word),
      .count   (count)
   );

   kic_match u_match (
      .word       (word),
      .count      (count),
      .kind       (kind),
      .word_index (word_index)
   );

   always_comb begin
      first_in = '0;
      rest_in = '0;
      for (int unsigned i = 0; i < OUT_TEXT_BYTES; i++) begin
         if (i < MAX_CHARS) begin
            if (i < 8) begin
               first_in[8*i +: 8] = word[i];
            end else begin
               rest_in[8*(i-8) +: 8] = word[i];
            end
         end
      end
      if (count > CNT_W'(OUT_TEXT_BYTES)) begin
         length_in = LENGTH_W'(OUT_TEXT_BYTES);
      end else begin
         length_in = count[LENGTH_W-1:0];
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         kind_ff   <= kind;
         index_ff  <= word_index;
         first_ff  <= first_in;
         rest_ff   <= rest_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_word_index = index_ff;
   assign rsp_text_first = first_ff;
   assign rsp_text_rest  = rest_ff;
   assign rsp_length     = length_ff;

   a_ident_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_IDENT |-> rsp_word_index == '0)
      else $error("identifier word carries a nonzero index");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length != '0)
      else $error("result word with zero length");

   a_short_rest_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length <= 4'd8 |-> rsp_text_rest == '0)
      else $error("short word has characters in upper text");

   a_blocked_last_stalls: assert property (@(posedge clock) disable iff (reset)
      ctl.valid && ctl.last && rsp_valid && rsp_stall |-> req_stall)
      else $error("last character advanced into a held result");

endmodule

`default_nettype wire

FILE: tb/tb_keyword_identifier_classifier.sv
`timescale 1ns / 100ps

module tb_keyword_identifier_classifier;
   import kic_pkg::*;

   localparam int KEPT_MAX    = 15;
   localparam int TEXT_SHOWN  = 15;
   localparam int N_OPS       = 6;
   localparam int N_RESERVED  = 29;
   localparam int STIM_WORDS  = 1850;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } char_word_t;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  word_index;
      logic [63:0] text_first;
      logic [55:0] text_rest;
      logic [3:0]  length;
   } word_class_t;

   string op_words [N_OPS] = '{"and", "or", "not", "div", "mod", "in"};
   string res_words [N_RESERVED] = '{
      "array", "begin", "case", "const", "do", "downto", "else", "end",
      "file", "for", "function", "goto", "if", "label", "nil", "of",
      "packed", "procedure", "program", "record", "repeat", "set", "then",
      "to", "type", "while", "var", "until", "with"
   };

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = '0;
   logic        req_last      = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [1:0]  rsp_kind;
   logic [4:0]  rsp_word_index;
   logic [63:0] rsp_text_first;
   logic [55:0] rsp_text_rest;
   logic [3:0]  rsp_length;

   char_word_t  pending_chars [$];
   logic [7:0]  word_bytes [$];
   word_class_t expected_words [$];
   char_word_t  head_char;
   word_class_t want;

   logic [7:0]  kept_text [KEPT_MAX];
   int          kept_cnt      = 0;
   int          n_accepted    = 0;
   int          n_checked     = 0;
   int          n_errors      = 0;
   int          send_idle_pct = 20;
   int          recv_idle_pct = 80;
   int          hold_left     = 0;
   logic        hold_done     = 1'b0;

   keyword_identifier_classifier u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_word_index (rsp_word_index),
      .rsp_text_first (rsp_text_first),
      .rsp_text_rest  (rsp_text_rest),
      .rsp_length     (rsp_length)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit kept_equals(input string w);
      bit eq;
      eq = (w.len() == kept_cnt);
      for (int i = 0; i < w.len() && eq; i++) begin
         if (kept_text[i] != w[i]) begin
            eq = 1'b0;
         end
      end
      return eq;
   endfunction

   task automatic classify_char(input logic [7:0] ch, input logic fin);
      logic [7:0]  c;
      word_class_t r;
      bit          found;
      c = ch;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         c = c + CASE_OFFSET;
      end
      if (kept_cnt < KEPT_MAX) begin
         kept_text[kept_cnt] = c;
         kept_cnt++;
      end
      if (fin) begin
         r = '0;
         r.kind = KIND_IDENT;
         found = 1'b0;
         for (int k = 0; k < N_OPS && !found; k++) begin
            if (kept_equals(op_words[k])) begin
               found = 1'b1;
               r.kind = KIND_OPERATOR;
               r.word_index = 5'(k);
            end
         end
         for (int k = 0; k < N_RESERVED && !found; k++) begin
            if (kept_equals(res_words[k])) begin
               found = 1'b1;
               r.kind = KIND_RESERVED;
               r.word_index = 5'(k);
            end
         end
         for (int i = 0; i < TEXT_SHOWN && i < kept_cnt; i++) begin
            if (i < 8) begin
               r.text_first[8*i +: 8] = kept_text[i];
            end else begin
               r.text_rest[8*(i-8) +: 8] = kept_text[i];
            end
         end
         r.length = 4'(kept_cnt > TEXT_SHOWN ? TEXT_SHOWN : kept_cnt);
         expected_words.push_back(r);
         kept_cnt = 0;
      end
   endtask

   function automatic void add_text(input string s, input bit mix_case);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (mix_case && c >= 8'h61 && c <= 8'h7a && $urandom_range(1) == 1) begin
            c = c - CASE_OFFSET;
         end
         word_bytes.push_back(c);
      end
   endfunction

   function automatic void add_ident(input int n, input bit any_bytes);
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         if (any_bytes && $urandom_range(3) == 0) begin
            c = 8'($urandom_range(255));
         end else if (i == 0 || $urandom_range(2) != 0) begin
            c = 8'($urandom_range(25)) + (($urandom_range(1) == 1) ? 8'h41 : 8'h61);
         end else begin
            c = 8'h30 + 8'($urandom_range(9));
         end
         word_bytes.push_back(c);
      end
   endfunction

   function automatic string pick_keyword();
      int k;
      k = $urandom_range(N_OPS + N_RESERVED - 1);
      return (k < N_OPS) ? op_words[k] : res_words[k - N_OPS];
   endfunction

   function automatic void flush_word();
      char_word_t w;
      foreach (word_bytes[i]) begin
         w.ch  = word_bytes[i];
         w.fin = (i == word_bytes.size() - 1);
         pending_chars.push_back(w);
      end
      word_bytes.delete();
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid     <= 1'b0;
         req_character <= '0;
         req_last      <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            classify_char(req_character, req_last);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               head_char = pending_chars.pop_front();
               req_valid     <= 1'b1;
               req_character <= head_char.ch;
               req_last      <= head_char.fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the pipe backs up into the input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && n_checked >= 40) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("word with none expected: kind %0d length %0d", rsp_kind, rsp_length);
               n_errors++;
            end else begin
               want = expected_words.pop_front();
               n_checked++;
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  n_errors++;
               end
               if (rsp_word_index !== want.word_index) begin
                  $error("word_index: expected %0d, got %0d", want.word_index, rsp_word_index);
                  n_errors++;
               end
               if (rsp_text_first !== want.text_first) begin
                  $error("text_first: expected %h, got %h", want.text_first, rsp_text_first);
                  n_errors++;
               end
               if (rsp_text_rest !== want.text_rest) begin
                  $error("text_rest: expected %h, got %h", want.text_rest, rsp_text_rest);
                  n_errors++;
               end
               if (rsp_length !== want.length) begin
                  $error("length: expected %0d, got %0d", want.length, rsp_length);
                  n_errors++;
               end
            end
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin : stimulus
      int    sel;
      int    n_total;
      int    spins;
      int    pos;
      string kw;

      // directed words
      add_text("z", 1'b0);
      flush_word();
      add_text("PrOcEdUrE", 1'b0);
      flush_word();
      add_text("in", 1'b0);
      flush_word();
      add_text("AND", 1'b0);
      flush_word();
      add_text("Ab9", 1'b0);
      word_bytes.push_back(8'hff);
      word_bytes.push_back(8'h80);
      add_text("qrstuvwxyzKLM", 1'b0);
      flush_word();
      add_text("a", 1'b0);
      word_bytes.push_back(8'h00);
      flush_word();
      add_text("7with", 1'b0);
      flush_word();

      // random words, mostly well formed
      while (pending_chars.size() < STIM_WORDS) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            add_text(pick_keyword(), 1'b1);
         end else if (sel < 60) begin
            kw = pick_keyword();
            add_text(kw, 1'b1);
            case ($urandom_range(2))
               0: begin
                  add_ident(1, 1'b0);
               end
               1: begin
                  void'(word_bytes.pop_back());
                  if (word_bytes.size() == 0) begin
                     add_ident(1, 1'b0);
                  end
               end
               default: begin
                  pos = $urandom_range(kw.len() - 1);
                  word_bytes[pos] = 8'($urandom_range(25)) + 8'h61;
               end
            endcase
         end else if (sel < 90) begin
            if ($urandom_range(9) == 0) begin
               add_ident($urandom_range(24, 9), 1'b0);
            end else begin
               add_ident($urandom_range(8, 1), 1'b0);
            end
         end else begin
            add_ident($urandom_range(20, 1), 1'b1);
         end
         flush_word();
      end
      n_total = pending_chars.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (n_accepted >= n_total / 3);
      send_idle_pct = 80;
      recv_idle_pct = 20;
      wait (n_accepted >= 2 * n_total / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait (n_accepted == n_total);

      spins = 0;
      while (expected_words.size() != 0 && spins < 2000) begin
         @(posedge clock);
         spins++;
      end
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d words never arrived", expected_words.size());
         n_errors++;
      end

      if (n_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
